// File: rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared types and constants of the arbitrary block deframer
// Holds the parse phases, the output modes, the status codes and the layout
// of one result item that travels from the parser to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

  // Largest number of decimal length digits that a definite block may declare.
  localparam int MaxLenDigits = 9;

  localparam logic [7:0] CharHash    = 8'h23;  // '#'
  localparam logic [7:0] CharZero    = 8'h30;  // '0'
  localparam logic [7:0] CharOne     = 8'h31;  // '1'
  localparam logic [7:0] CharNine    = 8'h39;  // '9'
  localparam logic [7:0] CharNewline = 8'h0A;  // '\n'

  localparam int LenWidth = 30;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_INDEF,
    PH_LENGTH,
    PH_DATA,
    PH_WAIT
  } phase_e;

  typedef enum logic [1:0] {
    MODE_DENY,
    MODE_DECODE,
    MODE_VERIFY
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_INDEF_DENIED,
    ST_DEF_DENIED,
    ST_DIGITS_CUT,
    ST_DATA_SHORT,
    ST_GARBLED
  } status_e;

  typedef struct packed {
    logic       is_status;
    logic [7:0] out_byte;
    status_e    status_code;
    logic       run_last;
  } abd_item_t;

  // Up to two result items written to the queue in one cycle.
  typedef struct packed {
    logic [1:0]          cnt;
    abd_item_t [1:0]     items;
  } abd_wr_t;

endpackage

`default_nettype wire

// File: rtl/abd_in_if.sv
// ----------------------------------------------------------------------------
// abd_in_if: input byte channel
// Carries one response byte per beat with its last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface abd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/abd_out_if.sv
// ----------------------------------------------------------------------------
// abd_out_if: result channel
// Carries one payload byte or the final status of a response per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface abd_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] out_byte;
  logic [2:0] status_code;
  logic       run_last;

  modport source (output valid, output is_status, output out_byte,
                  output status_code, output run_last, input ready);
  modport sink   (input valid, input is_status, input out_byte,
                  input status_code, input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/abd_parser.sv
// ----------------------------------------------------------------------------
// abd_parser: per-byte header parser
// Keeps the running parse state of one response and turns each accepted
// byte into zero, one or two result items for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_parser import abd_pkg::*; #(
  parameter int MAX_LEN_DIGITS = MaxLenDigits
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [3:0] fmt_i,
  input  wire logic       acc_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output abd_wr_t         wr_o
);

  localparam logic [3:0] MaxDigits = 4'(MAX_LEN_DIGITS);

  phase_e                phase_q, phase_d;
  mode_e                 mode_q, mode_d;
  status_e               pending_q, pending_d;
  logic [1:0]            idx_q, idx_d;
  logic [3:0]            digcnt_q, digcnt_d;
  logic [LenWidth-1:0]   length_q, length_d;
  logic                  stopped_q, stopped_d;
  logic [7:0]            held0_q, held0_d;
  logic [7:0]            held1_q, held1_d;

  logic                  is_digit;
  logic                  is_nonzero_digit;
  logic [3:0]            digit;
  logic [LenWidth-1:0]   len_next;
  logic [LenWidth-1:0]   len_upd;
  mode_e                 mode_sec;

  logic [1:0]            np;
  logic [7:0]            p0, p1;
  status_e               code;
  logic [1:0]            cnt;
  abd_item_t             st_item;

  assign is_digit         = (data_byte_i >= CharZero) && (data_byte_i <= CharNine);
  assign is_nonzero_digit = (data_byte_i >= CharOne) && (data_byte_i <= CharNine);
  assign digit            = 4'(data_byte_i - CharZero);

  // length * 10 + digit, kept to the field width.
  assign len_next = {length_q[LenWidth-4:0], 3'b000} + {length_q[LenWidth-2:0], 1'b0}
                  + LenWidth'(digit);
  assign len_upd  = (is_digit && !stopped_q) ? len_next : length_q;

  // Mode chosen at the second byte; deny whenever the block does not go on.
  always_comb begin
    mode_sec = MODE_DENY;
    if (data_byte_i == CharZero) begin
      mode_sec = fmt_i[0] ? MODE_DECODE : (fmt_i[1] ? MODE_VERIFY : MODE_DENY);
    end else if (is_nonzero_digit && (fmt_i[3:2] != 2'b00) && (digit <= MaxDigits)) begin
      mode_sec = fmt_i[2] ? MODE_DECODE : MODE_VERIFY;
    end
  end

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    pending_d = pending_q;
    idx_d     = (idx_q == 2'd3) ? idx_q : idx_q + 2'd1;
    digcnt_d  = digcnt_q;
    length_d  = length_q;
    stopped_d = stopped_q;
    held0_d   = held0_q;
    held1_d   = held1_q;

    unique case (phase_q)
      PH_FIRST: begin
        held0_d = data_byte_i;
        if (data_byte_i == CharHash) begin
          phase_d = PH_SECOND;
        end else begin
          phase_d   = PH_WAIT;
          pending_d = ST_GARBLED;
        end
      end
      PH_SECOND: begin
        if (data_byte_i == CharZero) begin
          phase_d = PH_INDEF;
          mode_d  = mode_sec;
        end else if (is_nonzero_digit) begin
          digcnt_d  = digit;
          length_d  = '0;
          stopped_d = 1'b0;
          if (fmt_i[3:2] == 2'b00) begin
            phase_d   = PH_WAIT;
            pending_d = ST_DEF_DENIED;
          end else if (digit > MaxDigits) begin
            phase_d   = PH_WAIT;
            pending_d = ST_DIGITS_CUT;
          end else begin
            phase_d = PH_LENGTH;
            mode_d  = mode_sec;
          end
        end else begin
          phase_d   = PH_WAIT;
          pending_d = ST_GARBLED;
        end
      end
      PH_INDEF: begin
        if (mode_q == MODE_DECODE) begin
          held1_d = data_byte_i;
        end
      end
      PH_LENGTH: begin
        length_d = len_upd;
        if (!is_digit) begin
          stopped_d = 1'b1;
        end
        digcnt_d = digcnt_q - 4'd1;
        if (digcnt_q <= 4'd1) begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        // The length register counts down the data bytes still owed.
        if (length_q != '0) begin
          length_d = length_q - LenWidth'(1);
        end
      end
      PH_WAIT: begin
      end
      default: begin
        phase_d = PH_FIRST;
      end
    endcase

    if (last_byte_i) begin
      phase_d   = PH_FIRST;
      mode_d    = MODE_DENY;
      pending_d = ST_OK;
      idx_d     = 2'd0;
      digcnt_d  = 4'd0;
      length_d  = '0;
      stopped_d = 1'b0;
    end
  end

  // Result items for the current byte.
  always_comb begin
    np = 2'd0;
    p0 = data_byte_i;
    p1 = data_byte_i;
    unique case (phase_q)
      PH_SECOND: begin
        if (!last_byte_i && (mode_sec == MODE_VERIFY)) begin
          np = 2'd2;
          p0 = held0_q;
        end
      end
      PH_INDEF: begin
        if (mode_q == MODE_VERIFY) begin
          np = 2'd1;
        end else if ((mode_q == MODE_DECODE) && (idx_q == 2'd3)) begin
          // Decode runs one byte behind so the closing newline is never sent.
          np = 2'd1;
          p0 = held1_q;
        end
      end
      PH_LENGTH: begin
        if (mode_q == MODE_VERIFY) begin
          np = 2'd1;
        end
      end
      PH_DATA: begin
        if ((mode_q == MODE_VERIFY) || (length_q != '0)) begin
          np = 2'd1;
        end
      end
      default: begin
        np = 2'd0;
      end
    endcase

    code = ST_GARBLED;
    if (idx_q < 2'd2) begin
      code = ST_SHORT;
    end else begin
      unique case (phase_q)
        PH_INDEF: begin
          if (data_byte_i != CharNewline) begin
            code = ST_GARBLED;
          end else begin
            code = (mode_q == MODE_DENY) ? ST_INDEF_DENIED : ST_OK;
          end
        end
        PH_LENGTH: begin
          if (digcnt_q <= 4'd1) begin
            code = (len_upd == '0) ? ST_OK : ST_DATA_SHORT;
          end else begin
            code = ST_DIGITS_CUT;
          end
        end
        PH_DATA: begin
          code = (length_q <= LenWidth'(1)) ? ST_OK : ST_DATA_SHORT;
        end
        PH_WAIT: begin
          code = pending_q;
        end
        default: begin
          code = ST_GARBLED;
        end
      endcase
    end

    cnt = np + {1'b0, last_byte_i};

    st_item = '{is_status: 1'b1, out_byte: 8'h00, status_code: code, run_last: 1'b0};

    if (np != 2'd0) begin
      wr_o.items[0] = '{is_status: 1'b0, out_byte: p0, status_code: ST_OK, run_last: 1'b0};
    end else begin
      wr_o.items[0] = st_item;
    end
    if (np == 2'd2) begin
      wr_o.items[1] = '{is_status: 1'b0, out_byte: p1, status_code: ST_OK, run_last: 1'b0};
    end else begin
      wr_o.items[1] = st_item;
    end
    wr_o.items[0].run_last = (cnt == 2'd1);
    wr_o.items[1].run_last = (cnt == 2'd2);
    wr_o.cnt = acc_i ? cnt : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      mode_q    <= MODE_DENY;
      pending_q <= ST_OK;
      idx_q     <= 2'd0;
      digcnt_q  <= 4'd0;
      length_q  <= '0;
      stopped_q <= 1'b0;
    end else if (acc_i) begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      pending_q <= pending_d;
      idx_q     <= idx_d;
      digcnt_q  <= digcnt_d;
      length_q  <= length_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/abd_out_queue.sv
// ----------------------------------------------------------------------------
// abd_out_queue: four-entry result queue
// Takes up to two result items per cycle from the parser and hands them to
// the output channel one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_out_queue import abd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  abd_wr_t    wr_i,
  output logic       space_o,
  abd_out_if.source  out_if
);

  abd_item_t  mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;
  abd_item_t  head;

  assign head    = mem_q[rd_ptr_q];
  assign pop     = out_if.valid && out_if.ready;
  // Room for the worst case of two items from the next byte.
  assign space_o = (count_q <= 3'd2);

  assign out_if.valid       = (count_q != 3'd0);
  assign out_if.is_status   = head.is_status;
  assign out_if.out_byte    = head.out_byte;
  assign out_if.status_code = head.status_code;
  assign out_if.run_last    = head.run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + wr_i.cnt;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, wr_i.cnt} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.items[0];
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= wr_i.items[1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/arbitrary_block_deframer.sv
// ----------------------------------------------------------------------------
// arbitrary_block_deframer: arbitrary block response deframer
// Feed the bytes of one instrument response on in_if, the final byte marked
// by last_byte. Indefinite ('#0' ... newline) and definite ('#', digit count,
// length digits, data) blocks are recognized. Depending on accepted_formats,
// the payload is decoded, passed through unchanged or denied. The user must
// write accepted_formats through cfg_we_i / cfg_wdata_i only while the block
// is idle; the block itself does not enforce this. Every response ends in one
// status beat on out_if (is_status high); payload beats come first, so the
// receiver drops them if the status is not ok. run_last marks the last beat
// caused by one input byte. Throughput: one input byte per cycle while
// in_if.ready is high; a byte takes its beats out one per cycle while
// out_if.ready is high, so a verified block's second byte gives two beats.
// A four-entry result queue sits between the parser and out_if; in_if.ready
// drops while fewer than two entries are free, so a stalled receiver holds the
// input back once three beats are waiting. Reset clears the parse state,
// the queue and accepted_formats (no format allowed).
// ----------------------------------------------------------------------------
`default_nettype none

module arbitrary_block_deframer import abd_pkg::*; #(
  parameter int MAX_LEN_DIGITS = MaxLenDigits
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  abd_in_if.sink          in_if,
  abd_out_if.source       out_if
);

  logic [3:0] fmt_q;
  logic       space;
  logic       acc;
  abd_wr_t    wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 4'h0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  assign in_if.ready = space;
  assign acc         = in_if.valid && space;

  abd_parser #(
    .MAX_LEN_DIGITS (MAX_LEN_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (fmt_q),
    .acc_i       (acc),
    .data_byte_i (in_if.data_byte),
    .last_byte_i (in_if.last_byte),
    .wr_o        (wr)
  );

  abd_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .space_o (space),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire
